// ----- src/ttce_pkg.sv -----
// Shared types, constants and a lookup function for the emergency brake checker.
// No dependencies; used by every other file of the block.
package ttce_pkg;

   localparam int SPEED_W  = 16;
   localparam int RANGE_W  = 16;
   localparam int ANG_W    = 24;
   localparam int STEP_W   = 23;
   localparam int TTC_W    = 16;
   localparam int IDX_W    = 11;
   localparam int CSR_W    = 24;
   localparam int CSR_IDX_W = 2;
   localparam int XY_W     = 34;
   localparam int Z_W      = 36;
   localparam int P_W      = 50;
   localparam int REM_W    = 64;
   localparam int Q_W      = 17;
   localparam int STEP_CNT_W = 5;
   localparam int ATAN_W   = 20;

   localparam int MAX_BEAMS_DEF    = 2048;
   localparam int CORDIC_STEPS_DEF = 18;

   localparam int RED_TOP = 12;
   localparam int DIV_TOP = 16;
   localparam int RANGE_SHIFT = 38;

   localparam logic signed [Z_W-1:0]  ANG_PI      = 36'sd3294199;
   localparam logic signed [Z_W-1:0]  ANG_HALF_PI = 36'sd1647099;
   localparam logic signed [Z_W-1:0]  ANG_TWO_PI  = 36'sd6588398;
   localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic [TTC_W-1:0] TTC_INF = 16'hFFFF;
   localparam logic [TTC_W-1:0] TTC_SAT = 16'hFFFE;

   localparam logic [TTC_W-1:0]        THRESHOLD_RST = 16'd1250;
   localparam logic signed [ANG_W-1:0] START_RST     = -24'sd2464154;
   localparam logic [STEP_W-1:0]       STEP_RST      = 23'd4575;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_START     = 2'd1,
      CSR_STEP      = 2'd2
   } csr_idx_type;

   typedef enum logic [3:0] {
      DP_NONE, DP_LOAD, DP_VEC, DP_ODO_WR, DP_ANGLE, DP_REDUCE,
      DP_FOLD, DP_ROT, DP_MULT, DP_DCHK, DP_DIV, DP_UPDATE
   } dp_op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DISPATCH, ST_VEC, ST_ODO_WR, ST_ANGLE, ST_REDUCE,
      ST_FOLD, ST_ROT, ST_MULT, ST_DCHK, ST_DIV, ST_UPDATE
   } state_type;

   typedef struct packed {
      dp_op_type             op;
      logic [STEP_CNT_W-1:0] step;
   } dp_cmd_type;

   typedef struct packed {
      logic is_beam;
      logic is_last;
      logic out_block;
   } dp_status_type;

   function automatic logic [ATAN_W-1:0] atan_q20(input logic [STEP_CNT_W-1:0] i);
      logic [ATAN_W-1:0] v;
      case (i)
         5'd0:  v = 20'd823550;
         5'd1:  v = 20'd486170;
         5'd2:  v = 20'd256879;
         5'd3:  v = 20'd130396;
         5'd4:  v = 20'd65451;
         5'd5:  v = 20'd32757;
         5'd6:  v = 20'd16383;
         5'd7:  v = 20'd8192;
         5'd8:  v = 20'd4096;
         5'd9:  v = 20'd2048;
         5'd10: v = 20'd1024;
         5'd11: v = 20'd512;
         5'd12: v = 20'd256;
         5'd13: v = 20'd128;
         5'd14: v = 20'd64;
         5'd15: v = 20'd32;
         5'd16: v = 20'd16;
         5'd17: v = 20'd8;
         5'd18: v = 20'd4;
         5'd19: v = 20'd2;
         5'd20: v = 20'd1;
         default: v = 20'd0;
      endcase
      return v;
   endfunction

endpackage

// ----- src/ttce_if.sv -----
// Request and response channel interfaces (valid/ready plus payload).
// Depends on ttce_pkg for field widths.
interface ttce_req_if;
   logic                            valid;
   logic                            ready;
   logic                            operation;
   logic signed [ttce_pkg::SPEED_W-1:0] forward_speed;
   logic signed [ttce_pkg::SPEED_W-1:0] lateral_speed;
   logic [ttce_pkg::RANGE_W-1:0]    beam_range;
   logic                            range_valid;
   logic                            last_beam;
   modport source (output valid, operation, forward_speed, lateral_speed,
                   beam_range, range_valid, last_beam, input ready);
   modport sink   (input valid, operation, forward_speed, lateral_speed,
                   beam_range, range_valid, last_beam, output ready);
endinterface

interface ttce_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          brake;
   logic [ttce_pkg::TTC_W-1:0]    min_ttc_ms;
   logic [ttce_pkg::IDX_W-1:0]    min_beam_index;
   modport source (output valid, brake, min_ttc_ms, min_beam_index, input ready);
   modport sink   (input valid, brake, min_ttc_ms, min_beam_index, output ready);
endinterface

// ----- src/ttc_emergency_brake.sv -----
// Emergency brake checker top level: controller, datapath, channel ports.
// Each request runs through the shared CORDIC; a beam request also runs the 13-step angle
// reduction and the 17-step divider before the scan state update. One request at a time: the
// next one is accepted in the cycle after the previous finishes; a last beam also waits while
// an earlier response is still held.
// Reset (synchronous, active high): registers to defaults, scan state cleared.
module ttc_emergency_brake #(
   parameter int MAX_BEAMS    = ttce_pkg::MAX_BEAMS_DEF,
   parameter int CORDIC_STEPS = ttce_pkg::CORDIC_STEPS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   ttce_req_if.sink                       req_chan,
   ttce_rsp_if.source                     rsp_chan,
   input  logic                           csr_write,
   input  logic [ttce_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ttce_pkg::CSR_W-1:0]     csr_data
);
   import ttce_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   ttce_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   ttce_dp #(.MAX_BEAMS(MAX_BEAMS)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .cmd            (cmd),
      .status         (status),
      .in_operation   (req_chan.operation),
      .in_forward     (req_chan.forward_speed),
      .in_lateral     (req_chan.lateral_speed),
      .in_range       (req_chan.beam_range),
      .in_range_valid (req_chan.range_valid),
      .in_last        (req_chan.last_beam),
      .out_valid      (rsp_chan.valid),
      .out_ready      (rsp_chan.ready),
      .out_brake      (rsp_chan.brake),
      .out_ttc        (rsp_chan.min_ttc_ms),
      .out_index      (rsp_chan.min_beam_index)
   );

endmodule

// ----- src/ttce_ctrl.sv -----
// Sequencing state machine: issues datapath commands and step indexes.
// Depends on ttce_pkg.
module ttce_ctrl #(
   parameter int CORDIC_STEPS = ttce_pkg::CORDIC_STEPS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output ttce_pkg::dp_cmd_type   cmd,
   input  ttce_pkg::dp_status_type status
);
   import ttce_pkg::*;

   localparam logic [STEP_CNT_W-1:0] CS_LAST = STEP_CNT_W'(CORDIC_STEPS - 1);

   state_type             state_ff, state_in;
   logic [STEP_CNT_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      req_ready = 1'b0;
      cmd.op    = DP_NONE;
      cmd.step  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = DP_LOAD;
               state_in = ST_DISPATCH;
               step_in  = '0;
            end
         end
         ST_DISPATCH: begin
            state_in = status.is_beam ? ST_ANGLE : ST_VEC;
         end
         ST_VEC: begin
            cmd.op = DP_VEC;
            if (step_ff == CS_LAST) begin
               state_in = ST_ODO_WR;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_ODO_WR: begin
            cmd.op   = DP_ODO_WR;
            state_in = ST_IDLE;
         end
         ST_ANGLE: begin
            cmd.op   = DP_ANGLE;
            state_in = ST_REDUCE;
            step_in  = STEP_CNT_W'(RED_TOP);
         end
         ST_REDUCE: begin
            cmd.op = DP_REDUCE;
            if (step_ff == '0) begin
               state_in = ST_FOLD;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_FOLD: begin
            cmd.op   = DP_FOLD;
            state_in = ST_ROT;
            step_in  = '0;
         end
         ST_ROT: begin
            cmd.op = DP_ROT;
            if (step_ff == CS_LAST) begin
               state_in = ST_MULT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_MULT: begin
            cmd.op   = DP_MULT;
            state_in = ST_DCHK;
         end
         ST_DCHK: begin
            cmd.op   = DP_DCHK;
            state_in = ST_DIV;
            step_in  = STEP_CNT_W'(DIV_TOP);
         end
         ST_DIV: begin
            cmd.op = DP_DIV;
            if (step_ff == '0) begin
               state_in = ST_UPDATE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_UPDATE: begin
            // hold a last beam while the previous response is still pending
            if (!(status.is_last && status.out_block)) begin
               cmd.op   = DP_UPDATE;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ----- src/ttce_dp.sv -----
// Datapath: CSRs, scan state, shared CORDIC, angle reduction and divider.
// Depends on ttce_pkg; driven by ttce_ctrl commands.
module ttce_dp #(
   parameter int MAX_BEAMS = ttce_pkg::MAX_BEAMS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [ttce_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ttce_pkg::CSR_W-1:0]         csr_data,
   input  ttce_pkg::dp_cmd_type               cmd,
   output ttce_pkg::dp_status_type            status,
   input  logic                               in_operation,
   input  logic signed [ttce_pkg::SPEED_W-1:0] in_forward,
   input  logic signed [ttce_pkg::SPEED_W-1:0] in_lateral,
   input  logic [ttce_pkg::RANGE_W-1:0]       in_range,
   input  logic                               in_range_valid,
   input  logic                               in_last,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic                               out_brake,
   output logic [ttce_pkg::TTC_W-1:0]         out_ttc,
   output logic [ttce_pkg::IDX_W-1:0]         out_index
);
   import ttce_pkg::*;

   localparam int PROD_W = IDX_W + STEP_W;

   logic [TTC_W-1:0]        thresh_ff;
   logic signed [ANG_W-1:0] start_ff;
   logic [STEP_W-1:0]       astep_ff;

   logic                    op_ff, valid_ff, last_ff;
   logic signed [SPEED_W-1:0] fwd_ff, lat_ff;
   logic [RANGE_W-1:0]      range_ff;

   logic signed [SPEED_W-1:0] speed_ff;
   logic signed [ANG_W-1:0] slip_ff;
   logic [IDX_W-1:0]        cnt_ff;
   logic [TTC_W-1:0]        min_ff;
   logic [IDX_W-1:0]        idx_ff;

   logic signed [XY_W-1:0]  x_ff, y_ff;
   logic signed [Z_W-1:0]   z_ff;
   logic                    neg_ff;
   logic signed [P_W-1:0]   p_ff;
   logic [REM_W-1:0]        rem_ff;
   logic [Q_W-1:0]          q_ff;
   logic                    sat_ff, inf_ff;

   logic                    rsp_valid_ff;
   logic                    rsp_brake_ff;
   logic [TTC_W-1:0]        rsp_ttc_ff;
   logic [IDX_W-1:0]        rsp_idx_ff;

   logic signed [XY_W-1:0]  dx, dy, cval;
   logic signed [Z_W-1:0]   atan_z, red_thr, ang_sum, r1;
   logic [PROD_W-1:0]       prod;
   logic [REM_W-1:0]        pd, dsh;
   logic [TTC_W-1:0]        ttc, min_new;
   logic [IDX_W-1:0]        idx_new;
   logic                    take;

   assign dx      = y_ff >>> cmd.step;
   assign dy      = x_ff >>> cmd.step;
   assign atan_z  = Z_W'(atan_q20(cmd.step));
   assign red_thr = ANG_TWO_PI <<< cmd.step;
   assign prod    = PROD_W'(cnt_ff) * PROD_W'(astep_ff);
   assign ang_sum = Z_W'(start_ff) + $signed(Z_W'(prod)) + Z_W'(slip_ff)
                    + (ANG_TWO_PI <<< 2);
   assign r1      = (z_ff > ANG_PI) ? z_ff - ANG_TWO_PI : z_ff;
   assign cval    = neg_ff ? -x_ff : x_ff;
   assign pd      = REM_W'(p_ff[P_W-2:0]);
   assign dsh     = pd << cmd.step;

   always_comb begin
      if (inf_ff) begin
         ttc = TTC_INF;
      end else if (sat_ff || q_ff > Q_W'(TTC_SAT)) begin
         ttc = TTC_SAT;
      end else begin
         ttc = q_ff[TTC_W-1:0];
      end
      take    = ttc < min_ff;
      min_new = take ? ttc : min_ff;
      idx_new = take ? cnt_ff : idx_ff;
   end

   assign status.is_beam   = op_ff;
   assign status.is_last   = last_ff;
   assign status.out_block = rsp_valid_ff && !out_ready;

   assign out_valid = rsp_valid_ff;
   assign out_brake = rsp_brake_ff;
   assign out_ttc   = rsp_ttc_ff;
   assign out_index = rsp_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESHOLD_RST;
         start_ff  <= START_RST;
         astep_ff  <= STEP_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_THRESHOLD: thresh_ff <= csr_data[TTC_W-1:0];
            CSR_START:     start_ff  <= $signed(csr_data[ANG_W-1:0]);
            CSR_STEP:      astep_ff  <= csr_data[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff     <= '0;
         slip_ff      <= '0;
         cnt_ff       <= '0;
         min_ff       <= TTC_INF;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && out_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.op == DP_ODO_WR) begin
            speed_ff <= fwd_ff;
            slip_ff  <= (lat_ff > 0) ? z_ff[ANG_W-1:0] : '0;
         end
         if (cmd.op == DP_UPDATE) begin
            if (last_ff) begin
               rsp_valid_ff <= 1'b1;
               cnt_ff       <= '0;
               min_ff       <= TTC_INF;
               idx_ff       <= '0;
            end else begin
               min_ff <= min_new;
               idx_ff <= idx_new;
               if (32'(cnt_ff) == 32'(MAX_BEAMS - 1)) begin
                  cnt_ff <= '0;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == DP_UPDATE && last_ff) begin
         rsp_brake_ff <= (min_new != TTC_INF) && (min_new < thresh_ff);
         rsp_ttc_ff   <= min_new;
         rsp_idx_ff   <= idx_new;
      end
      case (cmd.op)
         DP_LOAD: begin
            op_ff    <= in_operation;
            fwd_ff   <= in_forward;
            lat_ff   <= in_lateral;
            range_ff <= in_range;
            valid_ff <= in_range_valid;
            last_ff  <= in_last;
            x_ff     <= XY_W'(in_lateral) <<< 14;
            y_ff     <= XY_W'(in_forward) <<< 14;
            z_ff     <= '0;
         end
         DP_VEC: begin
            if (y_ff > 0) begin
               x_ff <= x_ff + dx;
               y_ff <= y_ff - dy;
               z_ff <= z_ff + atan_z;
            end else begin
               x_ff <= x_ff - dx;
               y_ff <= y_ff + dy;
               z_ff <= z_ff - atan_z;
            end
         end
         DP_ANGLE: z_ff <= ang_sum;
         DP_REDUCE: begin
            if (z_ff >= red_thr) begin
               z_ff <= z_ff - red_thr;
            end
         end
         DP_FOLD: begin
            x_ff <= CORDIC_GAIN;
            y_ff <= '0;
            if (r1 > ANG_HALF_PI) begin
               z_ff   <= ANG_PI - r1;
               neg_ff <= 1'b1;
            end else if (r1 < -ANG_HALF_PI) begin
               z_ff   <= -ANG_PI - r1;
               neg_ff <= 1'b1;
            end else begin
               z_ff   <= r1;
               neg_ff <= 1'b0;
            end
         end
         DP_ROT: begin
            if (z_ff >= 0) begin
               x_ff <= x_ff - dx;
               y_ff <= y_ff + dy;
               z_ff <= z_ff - atan_z;
            end else begin
               x_ff <= x_ff + dx;
               y_ff <= y_ff - dy;
               z_ff <= z_ff + atan_z;
            end
         end
         DP_MULT: p_ff <= P_W'(speed_ff) * P_W'(cval);
         DP_DCHK: begin
            rem_ff <= REM_W'(range_ff) << RANGE_SHIFT;
            sat_ff <= (REM_W'(range_ff) << RANGE_SHIFT) >= (pd << Q_W);
            inf_ff <= !(valid_ff && p_ff > 0);
            q_ff   <= '0;
         end
         DP_DIV: begin
            if (rem_ff >= dsh) begin
               rem_ff <= rem_ff - dsh;
               q_ff   <= q_ff | (Q_W'(1) << cmd.step);
            end
         end
         default: ;
      endcase
   end

endmodule

// ----- verif/ttc_emergency_brake_tb.sv -----
// Self-checking testbench for the lidar emergency brake checker: random and directed
// odometry/beam requests, a scoreboard class predicting each scan verdict.
// Depends on ttce_pkg, ttce_if.sv (channel interfaces) and ttc_emergency_brake.
`timescale 1ns / 1ps

module ttc_emergency_brake_tb;
   import ttce_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic OP_ODOM = 1'b0;
   localparam logic OP_BEAM = 1'b1;
   localparam int   SCAN_BEAMS = 2048;
   localparam int   LONG_SCAN_BEAMS = 100;
   localparam int   ROT_STEPS = 18;
   localparam longint PI_Q20 = 3294199;
   localparam longint HALF_PI_Q20 = 1647099;
   localparam longint TWO_PI_Q20 = 6588398;
   localparam longint GAIN_Q30 = 652032874;
   localparam int   WATCHDOG_LIMIT = 20000;
   localparam int   DRAIN_CYCLES = 100;

   typedef struct {
      logic             brake;
      logic [TTC_W-1:0] min_ttc;
      logic [IDX_W-1:0] min_idx;
   } scan_verdict_type;

   class brake_scoreboard;
      longint        arctan_q20[24];
      logic [15:0]   threshold;
      logic signed [23:0] start_ang;
      logic [22:0]   step_ang;
      longint        speed;
      longint        slip;
      int            beam_cnt;
      int            min_ttc;
      int            min_idx;
      scan_verdict_type verdicts[$];
      int            errors;

      function new();
         arctan_q20 = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                        4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0};
         threshold = 16'd1250;
         start_ang = -24'sd2464154;
         step_ang  = 23'd4575;
         speed = 0;
         slip = 0;
         beam_cnt = 0;
         min_ttc = 65535;
         min_idx = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
         if (idx == CSR_THRESHOLD) threshold = data[15:0];
         else if (idx == CSR_START) start_ang = data[23:0];
         else if (idx == CSR_STEP) step_ang = data[22:0];
      endfunction

      function longint cosine_q30(longint a);
         longint r, x, y, dx, dy;
         bit neg;
         r = a % TWO_PI_Q20;
         x = GAIN_Q30;
         y = 0;
         neg = 0;
         if (r < 0) r += TWO_PI_Q20;
         if (r > PI_Q20) r -= TWO_PI_Q20;
         if (r > HALF_PI_Q20) begin
            r = PI_Q20 - r;
            neg = 1;
         end else if (r < -HALF_PI_Q20) begin
            r = -PI_Q20 - r;
            neg = 1;
         end
         for (int i = 0; i < ROT_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (r >= 0) begin
               x -= dx; y += dy; r -= arctan_q20[i];
            end else begin
               x += dx; y -= dy; r += arctan_q20[i];
            end
         end
         return neg ? -x : x;
      endfunction

      function longint slip_q20(longint num, longint den);
         longint x, y, z, dx, dy;
         x = den * 16384;
         y = num * 16384;
         z = 0;
         for (int i = 0; i < ROT_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
               x += dx; y -= dy; z += arctan_q20[i];
            end else begin
               x -= dx; y += dy; z -= arctan_q20[i];
            end
         end
         return z;
      endfunction

      function void note_request(logic op, logic signed [15:0] fwd, logic signed [15:0] lat,
                                 logic [15:0] range, logic rvalid, logic last);
         longint ang, c, p;
         longint unsigned q;
         int ttc;
         scan_verdict_type v;
         if (op == OP_ODOM) begin
            speed = longint'(fwd);
            slip = (lat > 0) ? slip_q20(longint'(fwd), longint'(lat)) : 0;
            return;
         end
         ttc = 65535;
         ang = longint'(start_ang) + longint'(beam_cnt) * longint'(step_ang) + slip;
         c = cosine_q30(ang);
         p = speed * c;
         if (rvalid && p > 0) begin
            q = (longint'(range) << 38) / p;
            ttc = (q > 65534) ? 65534 : int'(q);
         end
         if (ttc < min_ttc) begin
            min_ttc = ttc;
            min_idx = beam_cnt;
         end
         if (!last) begin
            beam_cnt = (beam_cnt + 1) % SCAN_BEAMS;
            return;
         end
         v.brake = (min_ttc != 65535) && (min_ttc < threshold);
         v.min_ttc = TTC_W'(min_ttc);
         v.min_idx = IDX_W'(min_idx);
         verdicts.insert(verdicts.size(), v);
         beam_cnt = 0;
         min_ttc = 65535;
         min_idx = 0;
      endfunction

      function void check_response(logic brake, logic [TTC_W-1:0] ttc, logic [IDX_W-1:0] idx);
         scan_verdict_type v;
         if (verdicts.size() == 0) begin
            $error("unexpected response brake=%0d min_ttc_ms=%0d min_beam_index=%0d",
                   brake, ttc, idx);
            errors++;
            return;
         end
         v = verdicts.pop_front();
         if (brake !== v.brake) begin
            $error("brake expected %0d actual %0d", v.brake, brake);
            errors++;
         end
         if (ttc !== v.min_ttc) begin
            $error("min_ttc_ms expected %0d actual %0d", v.min_ttc, ttc);
            errors++;
         end
         if (idx !== v.min_idx) begin
            $error("min_beam_index expected %0d actual %0d", v.min_idx, idx);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_write = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_data = '0;
   bit quiet = 0;
   bit hold_req = 0;
   int hold_cnt = 0;
   int idle_cycles = 0;

   ttce_req_if req_chan ();
   ttce_rsp_if rsp_chan ();
   brake_scoreboard sb = new();

   ttc_emergency_brake DUT (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   initial begin
      req_chan.valid = 0;
      req_chan.operation = 0;
      req_chan.forward_speed = 0;
      req_chan.lateral_speed = 0;
      req_chan.beam_range = 0;
      req_chan.range_valid = 0;
      req_chan.last_beam = 0;
      rsp_chan.ready = 0;
   end

   always @(negedge clock) begin
      if (hold_req) begin
         hold_cnt = 400;
         hold_req = 0;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_chan.ready <= 0;
      end else begin
         rsp_chan.ready <= quiet || ($urandom_range(99) >= 13);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         idle_cycles++;
         if (req_chan.valid && req_chan.ready) begin
            sb.note_request(req_chan.operation, req_chan.forward_speed, req_chan.lateral_speed,
                            req_chan.beam_range, req_chan.range_valid, req_chan.last_beam);
            idle_cycles = 0;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            sb.check_response(rsp_chan.brake, rsp_chan.min_ttc_ms, rsp_chan.min_beam_index);
            idle_cycles = 0;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   task automatic send(logic op, logic signed [15:0] fwd, logic signed [15:0] lat,
                       logic [15:0] range, logic rvalid, logic last);
      req_chan.valid <= 1;
      req_chan.operation <= op;
      req_chan.forward_speed <= fwd;
      req_chan.lateral_speed <= lat;
      req_chan.beam_range <= range;
      req_chan.range_valid <= rvalid;
      req_chan.last_beam <= last;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      @(negedge clock);
      if (!quiet && $urandom_range(99) < 13) begin
         req_chan.valid <= 0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   task automatic odom(logic signed [15:0] fwd, logic signed [15:0] lat);
      send(OP_ODOM, fwd, lat, 16'($urandom), 1'($urandom), 1'($urandom));
   endtask

   task automatic beam(logic [15:0] range, logic rvalid, logic last);
      send(OP_BEAM, 16'($urandom), 16'($urandom), range, rvalid, last);
   endtask

   task automatic settle();
      req_chan.valid <= 0;
      @(negedge clock);
      while (sb.verdicts.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_write <= 0;
   endtask

   task automatic configure(logic [15:0] thr, logic signed [23:0] start, logic [22:0] step);
      settle();
      write_csr(CSR_THRESHOLD, CSR_W'(thr));
      write_csr(CSR_START, start);
      write_csr(CSR_STEP, CSR_W'(step));
   endtask

   task automatic random_scans(int items);
      int n, cnt;
      logic signed [15:0] fwd;
      cnt = 0;
      while (cnt < items) begin
         if ($urandom_range(99) < 30) begin
            fwd = ($urandom_range(1) != 0) ? 16'($urandom) : 16'($urandom_range(7680));
            odom(fwd, ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2560)));
            cnt++;
         end
         if ($urandom_range(99) < 5) begin
            beam(16'($urandom), 1'($urandom), 1'($urandom));
            cnt++;
         end else begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
               beam(($urandom_range(1) != 0) ? 16'($urandom_range(3000)) : 16'($urandom),
                    $urandom_range(9) != 0, i == n - 1);
            cnt += n;
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      configure(16'd1250, -24'sd2464154, 23'd4575);
      write_csr(CSR_UNUSED, CSR_W'($urandom));
      beam(16'd1000, 1, 1);
      odom(16'sd32767, 16'sd1);
      beam(16'd0, 1, 0);
      beam(16'd65535, 1, 0);
      beam(16'd500, 0, 0);
      beam(16'd2000, 1, 1);
      odom(16'sd1, -16'sd5);
      beam(16'd65535, 1, 0);
      beam(16'd65535, 1, 1);
      odom(-16'sd32768, 16'sd32767);
      beam(16'd100, 1, 1);
      odom(16'sd2560, 16'sd0);
      beam(16'd500, 0, 0);
      beam(16'd500, 0, 1);
      odom(16'sd7680, -16'sd32768);
      beam(16'd3000, 1, 0);
      beam(16'd1500, 1, 0);
      beam(16'd1500, 1, 1);
      odom(16'sd0, 16'sd2000);
      beam(16'd800, 1, 1);
      random_scans(60);

      configure(16'd0, -24'sd8388608, 23'd0);
      random_scans(100);

      configure(16'd65534, 24'sd8388607, 23'd8388607);
      quiet = 1;
      random_scans(100);
      quiet = 0;

      configure(16'($urandom_range(65534)), 24'($urandom), 23'($urandom_range(20000)));
      hold_req = 1;
      random_scans(100);

      configure(16'd30000, 24'sd0, 23'd4575);
      odom(16'sd2560, 16'sd0);
      for (int i = 0; i < LONG_SCAN_BEAMS; i++)
         beam(16'($urandom), 1'($urandom), i == LONG_SCAN_BEAMS - 1);
      random_scans(20);

      req_chan.valid <= 0;
      while (sb.verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule

// ----- files.f -----
src/ttce_pkg.sv
src/ttce_if.sv
src/ttce_ctrl.sv
src/ttce_dp.sv
src/ttc_emergency_brake.sv
verif/ttc_emergency_brake_tb.sv
